/* design/tcpr_pkg.sv */
// Shared types, codes and constants for the Reno congestion window block.
// No dependencies; used by every module under design/.
`timescale 1ns / 1ps
`default_nettype none

package tcpr_pkg;

  // remainder pipeline shape: STAGES * STEPS_PER_STAGE must equal WORD_W
  localparam int WORD_W          = 16;
  localparam int STAGES          = 4;
  localparam int STEPS_PER_STAGE = 4;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SEGMENT   = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SPACE     = 2'd2;

  // event codes
  localparam logic OP_ACK     = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // phase codes
  localparam logic [1:0] PHASE_SS = 2'd0;
  localparam logic [1:0] PHASE_CA = 2'd1;
  localparam logic [1:0] PHASE_FR = 2'd2;

  localparam logic [7:0]  DUP_LIMIT = 8'd3;
  localparam logic [7:0]  DUP_MAX   = 8'd255;
  localparam logic [15:0] WIN_MAX   = 16'hFFFF;
  localparam logic [15:0] MIN_SPACE = 16'd2;

  // reset values
  localparam logic [15:0] RST_SEGMENT   = 16'd1024;
  localparam logic [15:0] RST_THRESHOLD = 16'd15360;
  localparam logic [15:0] RST_SPACE     = 16'd30720;
  localparam logic [15:0] RST_PEER_WIN  = 16'd1024;

  typedef struct packed {
    logic [15:0] segment_size;
    logic [15:0] initial_threshold;
    logic [15:0] sequence_space;
  } cfg_t;

  typedef struct packed {
    logic        seg_load;
    logic        thr_load;
    logic [15:0] data;
  } cfg_wr_t;

  // one event on its way through the remainder pipeline
  typedef struct packed {
    logic        opcode;
    logic [15:0] dvd;          // ack bits not yet shifted in, MSB first
    logic [15:0] rem;          // partial remainder, always below the space
    logic [15:0] peer_window;
  } item_t;

  // a space below two behaves as two
  function automatic logic [15:0] eff_space(input logic [15:0] s);
    return (s < MIN_SPACE) ? MIN_SPACE : s;
  endfunction

endpackage

`default_nettype wire

/* design/tcpr_cfg.sv */
// APB register file: segment size, initial threshold, sequence space.
// Depends on tcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpr_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcpr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tcpr_pkg::DATA_W-1:0]  pwdata,
  output logic      [tcpr_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output tcpr_pkg::cfg_t                    cfg,
  output tcpr_pkg::cfg_wr_t                 wr
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    wr.seg_load = 1'b0;
    wr.thr_load = 1'b0;
    wr.data     = pwdata[15:0];
    if (wr_en) begin
      unique case (reg_idx)
        tcpr_pkg::REG_SEGMENT:   wr.seg_load = 1'b1;
        tcpr_pkg::REG_THRESHOLD: wr.thr_load = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_size      <= tcpr_pkg::RST_SEGMENT;
      cfg.initial_threshold <= tcpr_pkg::RST_THRESHOLD;
      cfg.sequence_space    <= tcpr_pkg::RST_SPACE;
    end else if (wr_en) begin
      unique case (reg_idx)
        tcpr_pkg::REG_SEGMENT:   cfg.segment_size      <= pwdata[15:0];
        tcpr_pkg::REG_THRESHOLD: cfg.initial_threshold <= pwdata[15:0];
        tcpr_pkg::REG_SPACE:     cfg.sequence_space    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tcpr_pkg::REG_SEGMENT:   prdata = {16'd0, cfg.segment_size};
      tcpr_pkg::REG_THRESHOLD: prdata = {16'd0, cfg.initial_threshold};
      tcpr_pkg::REG_SPACE:     prdata = {16'd0, cfg.sequence_space};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/tcpr_mod_stage.sv */
// One stage of the ack-modulo-space pipeline: a few restoring remainder
// steps and a stage register with its own valid. Depends on tcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpr_mod_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [15:0]    space,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire tcpr_pkg::item_t up_item,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output tcpr_pkg::item_t     dn_item
);

  tcpr_pkg::item_t nxt;
  logic            en;

  always_comb begin
    logic [16:0] t;
    nxt = up_item;
    for (int i = 0; i < tcpr_pkg::STEPS_PER_STAGE; i++) begin
      t = {nxt.rem, nxt.dvd[15]};
      nxt.dvd = {nxt.dvd[14:0], 1'b0};
      if (t >= {1'b0, space}) begin
        t = t - {1'b0, space};
      end
      nxt.rem = t[15:0];
    end
  end

  // stage loads when empty or when its content moves on
  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      dn_item <= nxt;
    end
  end

endmodule

`default_nettype wire

/* design/tcpr_core.sv */
// Congestion window state update and result register.
// Depends on tcpr_pkg; takes items with the ack already reduced mod space.
`timescale 1ns / 1ps
`default_nettype none

module tcpr_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcpr_pkg::cfg_t    cfg,
  input  wire tcpr_pkg::cfg_wr_t wr,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire tcpr_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [15:0]            window_now,
  output logic [15:0]            threshold_now,
  output logic [1:0]             phase,
  output logic [7:0]             duplicates,
  output logic [15:0]            send_limit,
  output logic                   retransmit,
  output logic [15:0]            acked_upto
);

  logic [15:0] cong_window,  cong_window_next;
  logic [15:0] slow_threshold, slow_threshold_next;
  logic [1:0]  phase_reg,    phase_reg_next;
  logic [7:0]  dup_count,    dup_count_next;
  logic [15:0] last_acked,   last_acked_next;
  logic [15:0] previous_ack, previous_ack_next;
  logic [15:0] peer_window_reg, peer_window_reg_next;
  logic        retx_next;

  logic        en, fire;
  logic [15:0] half, seg, halved, ss_window, ca_window, fr_window;
  logic [7:0]  dup_inc;

  function automatic logic [15:0] sat16(input logic [18:0] v);
    return (v > {3'd0, tcpr_pkg::WIN_MAX}) ? tcpr_pkg::WIN_MAX : v[15:0];
  endfunction

  assign en         = !result_valid || result_ready;
  assign item_ready = en;
  assign fire       = item_valid && en;

  assign seg    = cfg.segment_size;
  assign half   = tcpr_pkg::eff_space(cfg.sequence_space) >> 1;
  assign halved = ((cong_window >> 1) > seg) ? (cong_window >> 1) : seg;

  assign ss_window = sat16({3'd0, cong_window} + {3'd0, seg});
  assign ca_window = sat16({3'd0, cong_window} + 19'd1);
  // halved + 3 * seg
  assign fr_window = sat16({3'd0, halved} + {3'd0, seg} + {2'd0, seg, 1'b0});
  assign dup_inc   = (dup_count == tcpr_pkg::DUP_MAX) ? dup_count : dup_count + 8'd1;

  always_comb begin
    cong_window_next     = cong_window;
    slow_threshold_next  = slow_threshold;
    phase_reg_next       = phase_reg;
    dup_count_next       = dup_count;
    last_acked_next      = last_acked;
    previous_ack_next    = previous_ack;
    peer_window_reg_next = peer_window_reg;
    retx_next            = 1'b0;

    if (item.opcode == tcpr_pkg::OP_ACK) begin
      // wrapped ack replaces a high mark; otherwise keep the larger
      if (item.rem < half && last_acked > half) begin
        last_acked_next = item.rem;
      end else if (item.rem > last_acked) begin
        last_acked_next = item.rem;
      end
      peer_window_reg_next = item.peer_window;

      if (last_acked_next != previous_ack) begin
        dup_count_next = '0;
        case (phase_reg)
          tcpr_pkg::PHASE_SS: begin
            cong_window_next = ss_window;
            if (ss_window >= slow_threshold) begin
              phase_reg_next = tcpr_pkg::PHASE_CA;
            end
          end
          tcpr_pkg::PHASE_CA: cong_window_next = ca_window;
          default: begin
            // leaving recovery: deflate to threshold
            cong_window_next = slow_threshold;
            phase_reg_next   = tcpr_pkg::PHASE_CA;
          end
        endcase
      end else if (phase_reg == tcpr_pkg::PHASE_SS || phase_reg == tcpr_pkg::PHASE_CA) begin
        dup_count_next = dup_inc;
        if (dup_inc >= tcpr_pkg::DUP_LIMIT) begin
          phase_reg_next      = tcpr_pkg::PHASE_FR;
          slow_threshold_next = halved;
          cong_window_next    = fr_window;
          retx_next           = 1'b1;
        end
      end else begin
        // duplicate in recovery inflates by one segment
        cong_window_next = ss_window;
      end
      previous_ack_next = last_acked_next;
    end else begin
      slow_threshold_next = halved;
      cong_window_next    = seg;
      dup_count_next      = '0;
      phase_reg_next      = tcpr_pkg::PHASE_SS;
      retx_next           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cong_window     <= tcpr_pkg::RST_SEGMENT;
      slow_threshold  <= tcpr_pkg::RST_THRESHOLD;
      phase_reg       <= tcpr_pkg::PHASE_SS;
      dup_count       <= '0;
      last_acked      <= '0;
      previous_ack    <= '0;
      peer_window_reg <= tcpr_pkg::RST_PEER_WIN;
      result_valid    <= 1'b0;
    end else begin
      if (wr.seg_load) begin
        cong_window <= wr.data;
      end else if (fire) begin
        cong_window <= cong_window_next;
      end
      if (wr.thr_load) begin
        slow_threshold <= wr.data;
      end else if (fire) begin
        slow_threshold <= slow_threshold_next;
      end
      if (fire) begin
        phase_reg       <= phase_reg_next;
        dup_count       <= dup_count_next;
        last_acked      <= last_acked_next;
        previous_ack    <= previous_ack_next;
        peer_window_reg <= peer_window_reg_next;
      end
      if (en) begin
        result_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      retransmit <= retx_next;
      send_limit <= (peer_window_reg_next < cong_window_next) ?
                    peer_window_reg_next : cong_window_next;
    end
  end

  // state moves on fire or APB writes, so it stands as the pending result
  assign window_now    = cong_window;
  assign threshold_now = slow_threshold;
  assign phase         = phase_reg;
  assign duplicates    = dup_count;
  assign acked_upto    = last_acked;

  a_fr_has_dups: assert property (@(posedge clk) disable iff (rst)
    phase_reg == tcpr_pkg::PHASE_FR |-> dup_count >= tcpr_pkg::DUP_LIMIT)
    else $error("recovery without three duplicates");

  a_limit_le_window: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> send_limit <= window_now)
    else $error("send limit above window");

  a_timeout_resets: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == tcpr_pkg::OP_TIMEOUT && !wr.seg_load |=>
      cong_window == $past(seg) && phase_reg == tcpr_pkg::PHASE_SS && retransmit)
    else $error("timeout did not reset window");

  a_retx_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && retransmit |->
      phase_reg == tcpr_pkg::PHASE_SS || phase_reg == tcpr_pkg::PHASE_FR)
    else $error("retransmit outside slow start or recovery");

endmodule

`default_nettype wire

/* design/tcp_reno_congestion_control_top.sv */
// Top level of the Reno congestion window block: APB registers, the
// ack remainder pipeline and the window update. Depends on tcpr_pkg,
// tcpr_cfg, tcpr_mod_stage and tcpr_core.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------------------
//   event    | event_valid / event_ready     | opcode, ack_number, peer_window
//   result   | result_valid / result_ready   | window_now, threshold_now, phase,
//            |                               | duplicates, send_limit, retransmit,
//            |                               | acked_upto
//   config   | APB psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
// Throughput: one item per cycle unless result_ready stalls a full pipeline.
//   Each item passes four remainder stages of four steps each, the first one
//   loaded at acceptance, then the update register that raises result_valid.
// The ack is reduced modulo the sequence space by restoring remainder steps,
//   one bit a step; that chain sets the pipeline depth.
// Each stage holds its item while the next is full, so bubbles still fill
//   when result_ready is low; event_ready drops only once every stage is full.
// Synchronous reset clears all control and window state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tcp_reno_congestion_control_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // config
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcpr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tcpr_pkg::DATA_W-1:0]  pwdata,
  output logic      [tcpr_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  // events
  input  wire logic                         event_valid,
  output logic                              event_ready,
  input  wire logic                         opcode,
  input  wire logic [15:0]                  ack_number,
  input  wire logic [15:0]                  peer_window,
  // results
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [15:0]                       window_now,
  output logic [15:0]                       threshold_now,
  output logic [1:0]                        phase,
  output logic [7:0]                        duplicates,
  output logic [15:0]                       send_limit,
  output logic                              retransmit,
  output logic [15:0]                       acked_upto
);

  tcpr_pkg::cfg_t    cfg;
  tcpr_pkg::cfg_wr_t wr;
  logic [15:0]       space;

  // stage k sits between chain slot k and slot k+1
  tcpr_pkg::item_t st_item  [tcpr_pkg::STAGES+1];
  logic            st_valid [tcpr_pkg::STAGES+1];
  logic            st_ready [tcpr_pkg::STAGES+1];

  tcpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .wr      (wr)
  );

  assign space = tcpr_pkg::eff_space(cfg.sequence_space);

  // entry: remainder starts at zero, ack bits feed in MSB first
  assign st_valid[0]         = event_valid;
  assign st_item[0].opcode   = opcode;
  assign st_item[0].dvd      = ack_number;
  assign st_item[0].rem      = '0;
  assign st_item[0].peer_window = peer_window;
  assign event_ready         = st_ready[0];

  for (genvar k = 0; k < tcpr_pkg::STAGES; k++) begin : g_mod
    tcpr_mod_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .space    (space),
      .up_valid (st_valid[k]),
      .up_ready (st_ready[k]),
      .up_item  (st_item[k]),
      .dn_valid (st_valid[k+1]),
      .dn_ready (st_ready[k+1]),
      .dn_item  (st_item[k+1])
    );
  end

  tcpr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .wr            (wr),
    .item_valid    (st_valid[tcpr_pkg::STAGES]),
    .item_ready    (st_ready[tcpr_pkg::STAGES]),
    .item          (st_item[tcpr_pkg::STAGES]),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .window_now    (window_now),
    .threshold_now (threshold_now),
    .phase         (phase),
    .duplicates    (duplicates),
    .send_limit    (send_limit),
    .retransmit    (retransmit),
    .acked_upto    (acked_upto)
  );

endmodule

`default_nettype wire

/* verif/tb_tcp_reno_congestion_control_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Reno congestion window block: directed and random
// ack/timeout items over several APB register settings, checked by an in-bench predictor.
// Depends on tcpr_pkg and tcp_reno_congestion_control_top.

module tb_tcp_reno_congestion_control_top;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 20;   // generous margin after the last result
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int MAX_LOGGED      = 100;  // keep the log bounded on a badly broken block

  // one result item, field order as on the result port list
  typedef struct packed {
    logic [15:0] window_now;
    logic [15:0] threshold_now;
    logic [1:0]  phase;
    logic [7:0]  duplicates;
    logic [15:0] send_limit;
    logic        retransmit;
    logic [15:0] acked_upto;
  } window_result_t;

  // Congestion window predictor plus the queue of results it has promised.
  class reno_window_scoreboard;
    logic [15:0] seg_size, start_thr, seq_space;
    logic [15:0] cwnd, ssthresh, last_ack, prev_ack, peer_win;
    logic [1:0]  cur_phase;
    logic [7:0]  dup_cnt;
    window_result_t expected_q[$];
    int mismatches;
    int checked;

    function new();
      seg_size   = tcpr_pkg::RST_SEGMENT;
      start_thr  = tcpr_pkg::RST_THRESHOLD;
      seq_space  = tcpr_pkg::RST_SPACE;
      cwnd       = tcpr_pkg::RST_SEGMENT;
      ssthresh   = tcpr_pkg::RST_THRESHOLD;
      cur_phase  = tcpr_pkg::PHASE_SS;
      dup_cnt    = '0;
      last_ack   = '0;
      prev_ack   = '0;
      peer_win   = tcpr_pkg::RST_PEER_WIN;
      mismatches = 0;
      checked    = 0;
    endfunction

    // register writes also reload the live window or threshold
    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        tcpr_pkg::REG_SEGMENT: begin
          seg_size = value;
          cwnd     = value;
        end
        tcpr_pkg::REG_THRESHOLD: begin
          start_thr = value;
          ssthresh  = value;
        end
        tcpr_pkg::REG_SPACE: seq_space = value;
        default: ;
      endcase
    endfunction

    function logic [15:0] clip(int unsigned v);
      return (v > 32'(tcpr_pkg::WIN_MAX)) ? tcpr_pkg::WIN_MAX : v[15:0];
    endfunction

    // new threshold after a loss: half the window, never below one segment
    function logic [15:0] halved();
      return ((cwnd >> 1) > seg_size) ? (cwnd >> 1) : seg_size;
    endfunction

    function void note_event(logic op, logic [15:0] ack, logic [15:0] pw);
      int unsigned space_eff, half, reduced;
      window_result_t r;
      r.retransmit = 1'b0;
      if (op == tcpr_pkg::OP_ACK) begin
        space_eff = (seq_space < tcpr_pkg::MIN_SPACE) ? 32'(tcpr_pkg::MIN_SPACE) :
                                                        32'(seq_space);
        half      = space_eff / 2;
        reduced   = 32'(ack) % space_eff;
        // a small ack after a large one means the sequence space wrapped
        if (reduced < half && 32'(last_ack) > half)
          last_ack = reduced[15:0];
        else if (reduced > 32'(last_ack))
          last_ack = reduced[15:0];
        peer_win = pw;
        if (last_ack != prev_ack) begin
          dup_cnt = '0;
          case (cur_phase)
            tcpr_pkg::PHASE_SS: begin
              cwnd = clip(32'(cwnd) + 32'(seg_size));
              if (cwnd >= ssthresh) cur_phase = tcpr_pkg::PHASE_CA;
            end
            tcpr_pkg::PHASE_CA: cwnd = clip(32'(cwnd) + 1);
            default: begin
              cwnd      = ssthresh;
              cur_phase = tcpr_pkg::PHASE_CA;
            end
          endcase
        end else if (cur_phase == tcpr_pkg::PHASE_SS || cur_phase == tcpr_pkg::PHASE_CA) begin
          if (dup_cnt < tcpr_pkg::DUP_MAX) dup_cnt++;
          if (dup_cnt >= tcpr_pkg::DUP_LIMIT) begin
            cur_phase    = tcpr_pkg::PHASE_FR;
            ssthresh     = halved();
            cwnd         = clip(32'(ssthresh) + 32'(tcpr_pkg::DUP_LIMIT) * 32'(seg_size));
            r.retransmit = 1'b1;
          end
        end else begin
          // recovery: every further duplicate inflates the window
          cwnd = clip(32'(cwnd) + 32'(seg_size));
        end
        prev_ack = last_ack;
      end else begin
        ssthresh     = halved();
        cwnd         = seg_size;
        dup_cnt      = '0;
        cur_phase    = tcpr_pkg::PHASE_SS;
        r.retransmit = 1'b1;
      end
      r.window_now    = cwnd;
      r.threshold_now = ssthresh;
      r.phase         = cur_phase;
      r.duplicates    = dup_cnt;
      r.send_limit    = (peer_win < cwnd) ? peer_win : cwnd;
      r.acked_upto    = last_ack;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_LOGGED)
        $display("[%0t] result %0d mismatch: %s", $time, checked, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(window_result_t got);
      window_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, window_now %0d", got.window_now));
      end else begin
        want = expected_q.pop_front();
        compare_field("window_now", got.window_now, want.window_now);
        compare_field("threshold_now", got.threshold_now, want.threshold_now);
        compare_field("phase", 16'(got.phase), 16'(want.phase));
        compare_field("duplicates", 16'(got.duplicates), 16'(want.duplicates));
        compare_field("send_limit", got.send_limit, want.send_limit);
        compare_field("retransmit", 16'(got.retransmit), 16'(want.retransmit));
        compare_field("acked_upto", got.acked_upto, want.acked_upto);
      end
      checked++;
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel, penable, pwrite;
  logic [tcpr_pkg::ADDR_W-1:0]   paddr;
  logic [tcpr_pkg::DATA_W-1:0]   pwdata;
  logic [tcpr_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          event_valid, event_ready;
  logic                          opcode;
  logic [15:0]                   ack_number, peer_window;
  logic                          result_valid, result_ready;
  logic [15:0]                   window_now, threshold_now, send_limit, acked_upto;
  logic [1:0]                    phase;
  logic [7:0]                    duplicates;
  logic                          retransmit;

  reno_window_scoreboard sb;
  int send_calm   = 0;
  int recv_calm   = 0;
  int cycle_count = 0;

  tcp_reno_congestion_control_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Random wait per item, with occasional stretches of back-to-back
  // traffic so both full-rate and stalled pipeline phases get exercised.
  function automatic int idle_cycles(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Peer windows: full range, small ones that bound the send limit, one equal
  // to the current window, and the maximum.
  function automatic logic [15:0] pick_window();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 2048));
      2:       return sb.cwnd;
      default: return tcpr_pkg::WIN_MAX;
    endcase
  endfunction

  // Present one item and hold it until accepted. Valid is only lowered when
  // a gap follows, so back-to-back items never see a low/high pair in one step.
  task automatic send_event(input logic op, input logic [15:0] ack, input logic [15:0] pw);
    int gap;
    gap = idle_cycles(send_calm);
    if (gap > 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_valid <= 1'b1;
    opcode      <= op;
    ack_number  <= ack;
    peer_window <= pw;
    @(posedge clk);
    while (!event_ready) @(posedge clk);
    sb.note_event(op, ack, pw);
  endtask

  // Stop sending and let every promised result come back.
  task automatic wait_drained();
    event_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; lands at the edge with pready high.
  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Mostly well-formed ack streams (advancing acks, duplicate runs that reach
  // fast recovery, timeouts) with stale and fully random acks mixed in.
  task automatic run_random(input int count);
    int          sent, kind, burst;
    int unsigned space_eff, a, step_max;
    logic        op;
    sent = 0;
    while (sent < count) begin
      space_eff = (sb.seq_space < tcpr_pkg::MIN_SPACE) ? 32'(tcpr_pkg::MIN_SPACE) :
                                                         32'(sb.seq_space);
      step_max  = (space_eff > 8) ? space_eff / 4 : 1;
      kind      = $urandom_range(0, 99);
      burst     = 1;
      op        = tcpr_pkg::OP_ACK;
      if (kind < 35) begin
        // advance by at most a quarter space (one for small spaces) so wraps look legitimate
        a = (32'(sb.last_ack) + $urandom_range(1, step_max)) % space_eff;
      end else if (kind < 60) begin
        a     = 32'(sb.last_ack);
        burst = $urandom_range(1, 5);
      end else if (kind < 70) begin
        a = $urandom_range(0, sb.last_ack);
      end else if (kind < 80) begin
        a  = $urandom_range(0, 65535);
        op = tcpr_pkg::OP_TIMEOUT;
      end else begin
        a = $urandom_range(0, 65535);
      end
      // now and then present the same ack one modulus higher, out of range
      if (kind < 70 && $urandom_range(0, 7) == 0 && a + space_eff <= 65535)
        a += space_eff;
      repeat (burst) begin
        send_event(op, a[15:0], pick_window());
        sent++;
      end
    end
  endtask

  // Result side: random ready stalls, every accepted result checked in order.
  initial begin : result_sink
    int gap;
    result_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = idle_cycles(recv_calm);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(window_result_t'{window_now, threshold_now, phase, duplicates,
                                       send_limit, retransmit, acked_upto});
  end

  initial begin : stimulus
    sb = new();
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    event_valid <= 1'b0;
    opcode      <= tcpr_pkg::OP_ACK;
    ack_number  <= '0;
    peer_window <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings: segment 1024, threshold 15360, space 30720.
    send_event(tcpr_pkg::OP_ACK, 16'd0, 16'd0);           // ack equals reset value: first dup
    send_event(tcpr_pkg::OP_ACK, 16'd0, 16'hFFFF);        // second duplicate
    send_event(tcpr_pkg::OP_ACK, 16'd30720, 16'd4096);    // ack == space reduces to 0: recovery
    send_event(tcpr_pkg::OP_ACK, 16'd0, 16'd8192);        // duplicate in recovery inflates
    send_event(tcpr_pkg::OP_ACK, 16'd1000, 16'hFFFF);     // new ack leaves recovery
    send_event(tcpr_pkg::OP_ACK, 16'd2000, 16'hFFFF);     // avoidance grows by one byte
    send_event(tcpr_pkg::OP_ACK, 16'd2000, 16'h5555);
    send_event(tcpr_pkg::OP_ACK, 16'd2000, 16'hAAAA);
    send_event(tcpr_pkg::OP_ACK, 16'd2000, 16'h1234);     // third duplicate from avoidance
    send_event(tcpr_pkg::OP_TIMEOUT, 16'hFFFF, 16'hFFFF); // timeout fields are ignored
    send_event(tcpr_pkg::OP_TIMEOUT, 16'd0, 16'd0);       // threshold floors at one segment
    send_event(tcpr_pkg::OP_ACK, 16'hFFFF, 16'hFFFF);     // out of range, reduced modulo space
    send_event(tcpr_pkg::OP_ACK, 16'd30719, 16'd100);     // top of sequence space
    send_event(tcpr_pkg::OP_ACK, 16'd5, 16'hFFFF);        // wraparound replaces the large value
    send_event(tcpr_pkg::OP_ACK, 16'd3, 16'hFFFF);        // stale ack counts as a duplicate
    send_event(tcpr_pkg::OP_ACK, 16'd15360, 16'hFFFF);    // exactly half the space
    send_event(tcpr_pkg::OP_ACK, 16'd100, 16'hFFFF);      // last at half, not above: no wrap
    for (int i = 1; i <= 8; i++)                          // avoidance grows by one per new ack
      send_event(tcpr_pkg::OP_ACK, 16'(15360 + 1000 * i), (i % 2 == 0) ? 16'h5555 : 16'hAAAA);

    // Random phases, each under its own register setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin : phase_loop
      logic [15:0] seg, thr, spc;
      case (p)
        0: begin seg = 16'd1;     thr = 16'd1;     spc = 16'd2;     end  // lower extremes
        1: begin                                                         // saturation
          seg = tcpr_pkg::WIN_MAX;
          thr = tcpr_pkg::WIN_MAX;
          spc = tcpr_pkg::WIN_MAX;
        end
        2: begin seg = 16'd0;     thr = 16'd3000;  spc = 16'd1;     end  // zero segment, tiny space
        3: begin
          seg = tcpr_pkg::RST_SEGMENT;
          thr = tcpr_pkg::RST_THRESHOLD;
          spc = tcpr_pkg::RST_SPACE;
        end
        4: begin
          seg = 16'($urandom_range(1, 64));
          thr = 16'($urandom_range(1, 65535));
          spc = 16'($urandom_range(2, 65535));
        end
        default: begin
          seg = 16'($urandom_range(1, 4096));
          thr = 16'($urandom_range(1, 65535));
          spc = 16'($urandom_range(2, 65535));
        end
      endcase
      wait_drained();
      apb_write(tcpr_pkg::REG_SEGMENT, seg);
      apb_write(tcpr_pkg::REG_THRESHOLD, thr);
      apb_write(tcpr_pkg::REG_SPACE, spc);
      run_random(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* tcp_reno_congestion_control_top.f */
design/tcpr_pkg.sv
design/tcpr_cfg.sv
design/tcpr_mod_stage.sv
design/tcpr_core.sv
design/tcp_reno_congestion_control_top.sv
verif/tb_tcp_reno_congestion_control_top.sv
